/* hw/rtl/sfci_pkg.sv */
// Package for the space-filling curve index unit: field widths, configuration
// register indexes, the curve tables and the record carried down the walk pipeline.
// No dependencies.
package sfci_pkg;

    // Field widths.
    localparam int COORD_W   = 32;
    localparam int COORD_Z_W = 21;
    localparam int CODE_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 2;

    // Default level counts and the number of curve levels resolved per pipeline stage.
    localparam int DEF_LEVELS_2D   = 32;
    localparam int DEF_LEVELS_3D   = 21;
    localparam int LEVELS_PER_STG  = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_DIMS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_KIND = 2'd1;

    // Register reset values and codes.
    localparam logic [1:0] DIMS_2D       = 2'd2;
    localparam logic [1:0] DIMS_RESET    = 2'd3;
    localparam logic       KIND_MORTON   = 1'b0;
    localparam logic       KIND_RESET    = 1'b1;

    // Unit cube visiting order of the 3D curve.
    localparam logic [2:0] UNIT_ORDER [8] = '{3'd0, 3'd7, 3'd3, 3'd4, 3'd1, 3'd6, 3'd2, 3'd5};

    // Quadrant orders of the 2D curve.
    localparam logic [1:0] QUAD_UD [4] = '{2'd0, 2'd3, 2'd1, 2'd2};
    localparam logic [1:0] QUAD_RL [4] = '{2'd3, 2'd2, 2'd0, 2'd1};

    // Rotation applied after each mapped 3D digit: target axis per source axis
    // (two bits each, axis 0 lowest) and a mirror bit per axis. Digits 2 and 5
    // leave the rotation alone.
    localparam logic [2:0][1:0] ROT_AXIS [8] = '{
        6'b001001, 6'b100001, 6'b000000, 6'b000110,
        6'b000110, 6'b000000, 6'b100001, 6'b001001
    };
    localparam logic [2:0] ROT_NEG [8] = '{
        3'b000, 3'b010, 3'b000, 3'b001, 3'b100, 3'b000, 3'b001, 3'b101
    };
    localparam logic [7:0] ROT_VALID   = 8'b1101_1011;
    localparam logic [7:0] FLIP_TOGGLE = 8'b0101_1010;
    localparam logic [2:0] DIGIT3_MASK = 3'b111;

    // Record of one point on its way down the walk pipeline. The work word holds
    // the remaining Morton digits, left aligned; the code collects output digits.
    typedef struct packed {
        logic              walk;
        logic              dim2;
        logic [CODE_W-1:0] work;
        logic [CODE_W-1:0] code;
        logic [1:0]        orient;
        logic [2:0][1:0]   axis;
        logic [2:0]        neg;
        logic              flip;
    } t_walk;

endpackage

/* hw/rtl/space_filling_curve_index.sv */
// Space-filling curve index unit: top level with configuration registers, Morton
// interleave and the staged Hilbert walk. Depends on sfci_pkg.
//
// Turns a point (x, y, z) into its Morton or Hilbert index, selected by the
// space_dims (2 for 2D, anything else 3D) and curve_kind registers. A new point
// is taken every clock cycle while o_stall is low. The point is loaded into the
// input register at the accepting edge, then passes through the walk stages, each
// for eight curve levels, and the result register, in that order. Stages hold their
// point independently, so a stalled result only stops the request side once the
// input register, every stage and the result register are full. Write the
// registers only while the unit is empty.
module space_filling_curve_index
    import sfci_pkg::*;
#(
    parameter int LEVELS_2D = DEF_LEVELS_2D,
    parameter int LEVELS_3D = DEF_LEVELS_3D
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Point requests.
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [COORD_W-1:0]   i_coord_x,
    input  logic [COORD_W-1:0]   i_coord_y,
    input  logic [COORD_Z_W-1:0] i_coord_z,
    // Results.
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CODE_W-1:0]    o_curve_code,
    // Configuration writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int LEVELS_MAX = (LEVELS_2D > LEVELS_3D) ? LEVELS_2D : LEVELS_3D;
    localparam int NUM_STG    = (LEVELS_MAX + LEVELS_PER_STG - 1) / LEVELS_PER_STG;
    localparam int ALIGN_2D   = CODE_W - 2 * LEVELS_2D;
    localparam int ALIGN_3D   = CODE_W - 3 * LEVELS_3D;

    // Fold an axis number into 0..2.
    function automatic logic [1:0] axis_mod3(input logic [1:0] a);
        return (a == 2'd3) ? 2'd0 : a;
    endfunction

    // One level of the 2D curve.
    function automatic t_walk step_2d(input t_walk a);
        t_walk      r;
        logic [1:0] d;
        logic [1:0] nd;
        r = a;
        d = a.work[CODE_W-1 -: 2];
        case (a.orient)
            2'd0:    nd = QUAD_UD[d];
            2'd1:    nd = QUAD_RL[d];
            2'd2:    nd = QUAD_UD[~d];
            default: nd = QUAD_RL[~d];
        endcase
        r.code = {a.code[CODE_W-3:0], (a.flip ? ~nd : nd)};
        r.work = {a.work[CODE_W-3:0], 2'b00};
        if (nd == 2'd0) begin
            r.orient = a.orient + 2'd1;
            r.flip   = ~a.flip;
        end
        if (nd == 2'd3) begin
            r.orient = a.orient + 2'd3;
            r.flip   = ~a.flip;
        end
        return r;
    endfunction

    // One level of the 3D curve: permute the digit, map it through the unit
    // order, then compose the rotation that the mapped digit calls for.
    function automatic t_walk step_3d(input t_walk a);
        t_walk      r;
        logic [2:0] d;
        logic [2:0] pd;
        logic [2:0] h;
        logic [1:0] k;
        r  = a;
        d  = a.work[CODE_W-1 -: 3];
        pd = '0;
        for (int i = 0; i < 3; i++) begin
            pd[axis_mod3(a.axis[i])] = d[i] ^ a.neg[i];
        end
        h = UNIT_ORDER[pd];
        r.code = {a.code[CODE_W-4:0], (a.flip ? (h ^ DIGIT3_MASK) : h)};
        r.work = {a.work[CODE_W-4:0], 3'b000};
        if (ROT_VALID[h]) begin
            for (int i = 0; i < 3; i++) begin
                k         = axis_mod3(a.axis[i]);
                r.axis[i] = ROT_AXIS[h][k];
                r.neg[i]  = ROT_NEG[h][k] ^ a.neg[i];
            end
        end
        if (FLIP_TOGGLE[h]) begin
            r.flip = ~a.flip;
        end
        return r;
    endfunction

    // Configuration registers.
    logic [1:0] r_space_dims;
    logic       r_curve_kind;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_dims <= DIMS_RESET;
            r_curve_kind <= KIND_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPACE_DIMS: r_space_dims <= i_cfg_data;
                CFG_CURVE_KIND: r_curve_kind <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline occupancy and the ready chain from the result side backward.
    logic                 r_in_vld;
    logic [NUM_STG-1:0]   r_stg_vld;
    logic                 r_out_vld;
    logic                 in_rdy;
    logic                 out_rdy;
    logic [NUM_STG-1:0]   stg_rdy;
    logic [NUM_STG-1:0]   stg_prev_vld;

    assign out_rdy = !r_out_vld || !i_stall;
    assign in_rdy  = !r_in_vld || stg_rdy[0];
    assign o_stall = !in_rdy;
    assign o_valid = r_out_vld;

    // Input register.
    logic [COORD_W-1:0]   r_in_x;
    logic [COORD_W-1:0]   r_in_y;
    logic [COORD_Z_W-1:0] r_in_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_rdy) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy && i_valid) begin
            r_in_x <= i_coord_x;
            r_in_y <= i_coord_y;
            r_in_z <= i_coord_z;
        end
    end

    // Morton interleave, x in the lowest bit of each digit, and walk setup.
    logic              dim2;
    logic [CODE_W-1:0] morton;
    t_walk             walk_init;

    assign dim2 = (r_space_dims == DIMS_2D);

    always_comb begin
        morton = '0;
        if (dim2) begin
            for (int i = 0; i < LEVELS_2D; i++) begin
                morton[2*i]   = r_in_x[i];
                morton[2*i+1] = r_in_y[i];
            end
        end else begin
            for (int i = 0; i < LEVELS_3D; i++) begin
                morton[3*i]   = r_in_x[i];
                morton[3*i+1] = r_in_y[i];
                morton[3*i+2] = r_in_z[i];
            end
        end
        walk_init.walk   = (r_curve_kind != KIND_MORTON);
        walk_init.dim2   = dim2;
        walk_init.work   = dim2 ? (morton << ALIGN_2D) : (morton << ALIGN_3D);
        walk_init.code   = walk_init.walk ? '0 : morton;
        walk_init.orient = 2'd0;
        walk_init.axis   = {2'd2, 2'd1, 2'd0};
        walk_init.neg    = 3'b000;
        walk_init.flip   = 1'b0;
    end

    // Walk stages, each resolving up to eight curve levels from the top.
    t_walk stg_in [NUM_STG];
    t_walk n_stg  [NUM_STG];
    t_walk r_stg  [NUM_STG];

    for (genvar s = 0; s < NUM_STG; s++) begin : g_stg
        if (s == 0) begin : g_first
            assign stg_in[s]       = walk_init;
            assign stg_prev_vld[s] = r_in_vld;
        end else begin : g_next
            assign stg_in[s]       = r_stg[s-1];
            assign stg_prev_vld[s] = r_stg_vld[s-1];
        end

        if (s == NUM_STG - 1) begin : g_last_rdy
            assign stg_rdy[s] = !r_stg_vld[s] || out_rdy;
        end else begin : g_mid_rdy
            assign stg_rdy[s] = !r_stg_vld[s] || stg_rdy[s+1];
        end

        always_comb begin
            t_walk cur;
            cur = stg_in[s];
            for (int t = 0; t < LEVELS_PER_STG; t++) begin
                if (cur.walk && cur.dim2 && (s * LEVELS_PER_STG + t < LEVELS_2D)) begin
                    cur = step_2d(cur);
                end else if (cur.walk && !cur.dim2
                             && (s * LEVELS_PER_STG + t < LEVELS_3D)) begin
                    cur = step_3d(cur);
                end
            end
            n_stg[s] = cur;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg_vld[s] <= 1'b0;
            end else if (stg_rdy[s]) begin
                r_stg_vld[s] <= stg_prev_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (stg_rdy[s] && stg_prev_vld[s]) begin
                r_stg[s] <= n_stg[s];
            end
        end
    end

    // Result register.
    logic [CODE_W-1:0] r_out_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_rdy) begin
            r_out_vld <= r_stg_vld[NUM_STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && r_stg_vld[NUM_STG-1]) begin
            r_out_code <= r_stg[NUM_STG-1].code;
        end
    end

    assign o_curve_code = r_out_code;

    // An empty result register always lets a request in.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> !o_stall)
        else $error("request stalled while result register is empty");

    // An accepted request lands in the input register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in_vld)
        else $error("accepted request lost at input register");

    // A 3D result never uses bits above three per level.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_space_dims != DIMS_2D))
            |-> ((r_out_code >> (3 * LEVELS_3D)) == '0))
        else $error("3D curve code has bits above its level count");

    // The last walk stage keeps its point while it cannot pass it on.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stg_vld[NUM_STG-1] && !out_rdy) |=> r_stg_vld[NUM_STG-1])
        else $error("last walk stage dropped a point under stall");

endmodule
